@@ hdl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;
    localparam int EW   = 32;           // element width
    localparam int FB   = 16;           // fraction bits
    localparam int NEL  = 9;            // elements per matrix
    localparam int NPR  = 2 * NEL;      // cofactor products
    localparam int LW   = 31;           // singular limit width
    localparam int PW   = 2 * EW;       // product width
    localparam int CW   = PW + 1;       // cofactor width
    localparam int SPW  = EW;           // low part of a split cofactor
    localparam int HW   = CW - SPW;     // high part of a split cofactor
    localparam int PPW  = EW + SPW + 1; // partial product width
    localparam int DETW = 3 * EW + 2;   // determinant width
    localparam int AW   = DETW;         // determinant magnitude width
    localparam int DW   = AW + 1;       // divisor width (twice the magnitude)
    localparam int NW   = DW + 1;       // dividend width
    localparam int SH   = 2 * FB + 1;   // dividend scaling shift
    localparam int QB   = EW + 1;       // quotient bits produced
    localparam int RW   = DW;           // partial remainder width
    localparam int NST  = QB + 8;       // pipeline stages, output register included

    localparam logic [EW-1:0] ONE_VAL = EW'(1) << FB;

    // Operand pairs for cofactor k: product 2k minus product 2k+1.
    localparam logic [3:0] MUL_A [NPR] = '{
        4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
        4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
    localparam logic [3:0] MUL_B [NPR] = '{
        4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
        4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};
endpackage
`default_nettype wire

@@ hdl/matrix3x3_inverse_unit.sv @@
// Channel | Direction | Word contents (lowest bits first)
// s_      | in        | tdata: r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2 (32 bits each)
// m_      | out       | tdata: inverse in the same order; tuser: singular, saturated
// cfg_    | in        | singular_limit, 31 bits, written when cfg_wr_en is high
//
// One word enters per cycle unless m_ stalls; the stages are: products, cofactors,
// determinant partial products, terms, determinant, magnitudes, dividend setup,
// 33 one-bit restoring divider stages and the output register.
// The divider stages, one quotient bit each, set the depth.
// Reset clears the valid bits and sets singular_limit to 1.
// A stall on m_ freezes the whole pipeline; s_tready drops in the same cycle.
`default_nettype none
module matrix3x3_inverse_unit
    import mi3_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [NEL*EW-1:0] s_tdata,   // r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [NEL*EW-1:0]      m_tdata,   // r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2
    output logic [1:0]             m_tuser,   // singular, saturated
    input  wire logic              cfg_wr_en,
    input  wire logic [LW-1:0]     cfg_wr_data
);
    logic              en;
    logic [NST-1:0]    vld_reg;
    logic [LW-1:0]     limit_reg;

    logic signed [EW-1:0]   el [NEL];
    logic signed [PW-1:0]   p1_reg [NPR];
    logic signed [EW-1:0]   p1_adg_reg [3];
    logic signed [CW-1:0]   p2_cof_reg [NEL];
    logic signed [EW-1:0]   p2_adg_reg [3];
    logic signed [PPW-1:0]  p3_lo_reg [3];
    logic signed [PPW-1:0]  p3_hi_reg [3];
    logic signed [CW-1:0]   p3_cof_reg [NEL];
    logic signed [DETW-1:0] p4_term_reg [3];
    logic signed [CW-1:0]   p4_cof_reg [NEL];
    logic signed [DETW-1:0] p5_det_reg;
    logic signed [CW-1:0]   p5_cof_reg [NEL];
    logic [AW-1:0]          p6_adet_reg;
    logic                   p6_sing_reg;
    logic [PW-1:0]          p6_mag_reg [NEL];
    logic                   p6_neg_reg [NEL];

    logic [DW-1:0]  dv_d_reg    [QB+1];
    logic           dv_sing_reg [QB+1];
    logic [RW-1:0]  dv_r_reg    [QB+1][NEL];
    logic [QB-1:0]  dv_nl_reg   [QB+1][NEL];
    logic [QB-1:0]  dv_q_reg    [QB+1][NEL];
    logic           dv_neg_reg  [QB+1][NEL];
    logic           dv_ovf_reg  [QB+1][NEL];

    logic [RW-1:0]  st_r [QB][NEL];
    logic           st_b [QB][NEL];

    logic [AW-1:0]  adet_next;
    logic [AW-1:0]  thr;
    logic [NW-1:0]  num_next [NEL];
    logic [NEL*EW-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        for (int k = 0; k < NEL; k++) begin
            el[k] = $signed(s_tdata[k*EW +: EW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            limit_reg <= LW'(1);
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (en) begin
                vld_reg <= {vld_reg[NST-2:0], s_tvalid};
            end
        end
    end

    // Magnitude of the determinant and the singular threshold (limit scaled to
    // the determinant's fraction bits).
    always_comb begin
        adet_next = p5_det_reg[DETW-1] ? AW'(-p5_det_reg) : AW'(p5_det_reg);
        thr       = AW'(limit_reg) << (2 * FB);
        for (int k = 0; k < NEL; k++) begin
            num_next[k] = (NW'(p6_mag_reg[k]) << SH) + NW'(p6_adet_reg);
        end
    end

    // One restoring step per stage: bring in the next dividend bit, then
    // subtract the divisor if it fits.
    always_comb begin
        logic [RW:0] t;
        for (int j = 0; j < QB; j++) begin
            for (int k = 0; k < NEL; k++) begin
                t = {dv_r_reg[j][k], dv_nl_reg[j][k][QB-1]};
                st_b[j][k] = t >= {1'b0, dv_d_reg[j]};
                st_r[j][k] = st_b[j][k] ? RW'(t - {1'b0, dv_d_reg[j]}) : RW'(t);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NPR; k++) begin
                p1_reg[k] <= el[MUL_A[k]] * el[MUL_B[k]];
            end
            p1_adg_reg[0] <= el[0];
            p1_adg_reg[1] <= el[3];
            p1_adg_reg[2] <= el[6];

            for (int k = 0; k < NEL; k++) begin
                p2_cof_reg[k] <= CW'(p1_reg[2*k]) - CW'(p1_reg[2*k+1]);
            end
            p2_adg_reg <= p1_adg_reg;

            // The determinant multiplies a 32-bit element by a 65-bit
            // cofactor, so the cofactor is split into two halves.
            for (int k = 0; k < 3; k++) begin
                p3_lo_reg[k] <= p2_adg_reg[k] * $signed({1'b0, p2_cof_reg[k][SPW-1:0]});
                p3_hi_reg[k] <= p2_adg_reg[k] * $signed(p2_cof_reg[k][CW-1:SPW]);
            end
            p3_cof_reg <= p2_cof_reg;

            for (int k = 0; k < 3; k++) begin
                p4_term_reg[k] <= (DETW'(p3_hi_reg[k]) <<< SPW) + DETW'(p3_lo_reg[k]);
            end
            p4_cof_reg <= p3_cof_reg;

            p5_det_reg <= p4_term_reg[0] + p4_term_reg[1] + p4_term_reg[2];
            p5_cof_reg <= p4_cof_reg;

            p6_adet_reg <= adet_next;
            p6_sing_reg <= adet_next <= thr;
            for (int k = 0; k < NEL; k++) begin
                p6_mag_reg[k] <= p5_cof_reg[k][CW-1] ? PW'(-p5_cof_reg[k])
                                                     : PW'(p5_cof_reg[k]);
                p6_neg_reg[k] <= p5_cof_reg[k][CW-1] ^ p5_det_reg[DETW-1];
            end

            dv_d_reg[0]    <= {p6_adet_reg, 1'b0};
            dv_sing_reg[0] <= p6_sing_reg;
            for (int k = 0; k < NEL; k++) begin
                dv_r_reg[0][k]   <= RW'(num_next[k] >> QB);
                dv_nl_reg[0][k]  <= num_next[k][QB-1:0];
                dv_q_reg[0][k]   <= '0;
                dv_neg_reg[0][k] <= p6_neg_reg[k];
                // A quotient that needs more than QB bits saturates anyway.
                dv_ovf_reg[0][k] <= (num_next[k] >> QB) >= NW'({p6_adet_reg, 1'b0});
            end

            for (int j = 0; j < QB; j++) begin
                dv_d_reg[j+1]    <= dv_d_reg[j];
                dv_sing_reg[j+1] <= dv_sing_reg[j];
                for (int k = 0; k < NEL; k++) begin
                    dv_r_reg[j+1][k]   <= st_r[j][k];
                    dv_nl_reg[j+1][k]  <= {dv_nl_reg[j][k][QB-2:0], 1'b0};
                    dv_q_reg[j+1][k]   <= {dv_q_reg[j][k][QB-2:0], st_b[j][k]};
                    dv_neg_reg[j+1][k] <= dv_neg_reg[j][k];
                    dv_ovf_reg[j+1][k] <= dv_ovf_reg[j][k];
                end
            end

            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    always_comb begin
        logic [QB-1:0] lim;
        logic [QB-1:0] mag;
        logic          sat;
        sat = 1'b0;
        for (int k = 0; k < NEL; k++) begin
            lim = dv_neg_reg[QB][k] ? (QB'(1) << (EW - 1)) : ((QB'(1) << (EW - 1)) - QB'(1));
            mag = dv_q_reg[QB][k];
            if (dv_ovf_reg[QB][k] || mag > lim) begin
                mag = lim;
                sat = 1'b1;
            end
            if (dv_sing_reg[QB]) begin
                m_tdata_next[k*EW +: EW] = (k % 4 == 0) ? ONE_VAL : '0;
            end else begin
                m_tdata_next[k*EW +: EW] = dv_neg_reg[QB][k] ? EW'(-mag) : EW'(mag);
            end
        end
        m_tuser_next = {sat && !dv_sing_reg[QB], dv_sing_reg[QB]};
    end

    a_sing_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[EW-1:0] == ONE_VAL && m_tdata[4*EW +: EW] == ONE_VAL
            && m_tdata[8*EW +: EW] == ONE_VAL && m_tdata[EW +: EW] == '0 && !m_tuser[1])
        else $error("singular word is not the identity");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word not in first stage");

    a_sat_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[EW-1:0] == {1'b0, {(EW-1){1'b1}}} || m_tdata[EW-1:0] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[2*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[2*EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[3*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[3*EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[4*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[4*EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[5*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[5*EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[6*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[6*EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[7*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[7*EW +: EW] == {1'b1, {(EW-1){1'b0}}}
            || m_tdata[8*EW +: EW] == {1'b0, {(EW-1){1'b1}}}
            || m_tdata[8*EW +: EW] == {1'b1, {(EW-1){1'b0}}})
        else $error("saturated flag without a clamped element");
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import mi3_pkg::*;

    localparam int WW = 192;
    localparam int PIPE_DEPTH = 41;

    typedef struct packed {
        logic [NEL*EW-1:0] elems;
        logic [1:0]        flags;   // singular, saturated
    } inverse_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [NEL*EW-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [NEL*EW-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_wr_en = 1'b0;
    logic [LW-1:0]     cfg_wr_data = '0;

    logic [NEL*EW-1:0] matrix_queue [$];
    inverse_t          inverse_queue [$];
    logic [LW-1:0]     limit_now = LW'(1);
    logic              in_taken = 1'b0;
    int                mismatches = 0;
    int                send_gap = 0;
    int                stall_left = 0;

    matrix3x3_inverse_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Back to back half the time, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic inverse_t invert(input logic [NEL*EW-1:0] m, input logic [LW-1:0] lim);
        logic signed [WW-1:0] e [NEL];
        logic signed [WW-1:0] cof [NEL];
        logic signed [WW-1:0] det;
        logic [WW-1:0] adet, thresh, num, q, cap;
        logic [EW-1:0] v;
        logic neg, sat;
        inverse_t r;
        for (int k = 0; k < NEL; k++) e[k] = $signed(m[k*EW +: EW]);
        cof[0] = e[4]*e[8] - e[5]*e[7];
        cof[1] = e[2]*e[7] - e[1]*e[8];
        cof[2] = e[1]*e[5] - e[2]*e[4];
        cof[3] = e[5]*e[6] - e[3]*e[8];
        cof[4] = e[0]*e[8] - e[2]*e[6];
        cof[5] = e[2]*e[3] - e[0]*e[5];
        cof[6] = e[3]*e[7] - e[4]*e[6];
        cof[7] = e[1]*e[6] - e[0]*e[7];
        cof[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*cof[0] + e[3]*cof[1] + e[6]*cof[2];
        adet = det[WW-1] ? -det : det;
        thresh = WW'(lim) << (2*FB);
        sat = 1'b0;
        if (adet <= thresh) begin
            for (int k = 0; k < NEL; k++) r.elems[k*EW +: EW] = (k % 4 == 0) ? ONE_VAL : '0;
            r.flags = 2'b01;
            return r;
        end
        for (int k = 0; k < NEL; k++) begin
            neg = cof[k][WW-1] ^ det[WW-1];
            num = (cof[k][WW-1] ? -cof[k] : cof[k]) << (2*FB);
            q = (2*num + adet) / (2*adet);
            cap = neg ? (WW'(1) << (EW-1)) : ((WW'(1) << (EW-1)) - 1);
            if (q > cap) begin
                q = cap;
                sat = 1'b1;
            end
            v = q[EW-1:0];
            if (neg) v = -v;
            r.elems[k*EW +: EW] = v;
        end
        r.flags = {sat, 1'b0};
        return r;
    endfunction

    // Sender: a word stays up until taken, then a random gap may follow.
    // Whether the word was taken is recorded at the rising edge itself.
    always @(negedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (aresetn && (!s_tvalid || in_taken)) begin
            next_valid = 1'b0;
            if (s_tvalid) send_gap = pick_gap();
            if (send_gap > 0) send_gap--;
            else if (matrix_queue.size() > 0) begin
                s_tdata <= matrix_queue.pop_front();
                next_valid = 1'b1;
            end
        end
        s_tvalid <= next_valid;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        inverse_t want;
        in_taken = s_tvalid && s_tready;
        if (s_tvalid && s_tready) inverse_queue.push_back(invert(s_tdata, limit_now));
        if (m_tvalid && m_tready) begin
            if (inverse_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h / %b", m_tdata, m_tuser);
            end else begin
                want = inverse_queue.pop_front();
                for (int k = 0; k < NEL; k++)
                    if (want.elems[k*EW +: EW] !== m_tdata[k*EW +: EW]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("element %0d: expected %h got %h", k,
                                     want.elems[k*EW +: EW], m_tdata[k*EW +: EW]);
                    end
                for (int k = 0; k < 2; k++)
                    if (want.flags[k] !== m_tuser[k]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("flag %0d: expected %b got %b", k, want.flags[k],
                                     m_tuser[k]);
                    end
            end
        end
    end

    function automatic logic [NEL*EW-1:0] diag(input logic [EW-1:0] x, input logic [EW-1:0] y,
                                              input logic [EW-1:0] z);
        logic [NEL*EW-1:0] m;
        m = '0;
        m[0 +: EW] = x;
        m[4*EW +: EW] = y;
        m[8*EW +: EW] = z;
        return m;
    endfunction

    function automatic logic [NEL*EW-1:0] random_matrix();
        logic [NEL*EW-1:0] m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < NEL; k++) begin
            if (kind < 3) m[k*EW +: EW] = $urandom();
            else if (kind < 8) m[k*EW +: EW] = EW'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            else m[k*EW +: EW] = EW'($signed($urandom_range(0, 255)) - 128);
        end
        // Near-singular: second row copies the first, sometimes nudged.
        if (kind == 7 || kind == 9) begin
            m[1*EW +: EW] = m[0*EW +: EW] + EW'($urandom_range(0, 2));
            m[4*EW +: EW] = m[3*EW +: EW];
            m[7*EW +: EW] = m[6*EW +: EW];
        end
        return m;
    endfunction

    task automatic wait_idle();
        while (matrix_queue.size() > 0 || s_tvalid || inverse_queue.size() > 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LW-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        limit_now = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [NEL*EW-1:0] m;
        logic [LW-1:0] limits [5];
        limits = '{LW'(0), {LW{1'b1}}, LW'(65536), LW'(1), LW'(0)};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset limit.
        matrix_queue.push_back(diag(ONE_VAL, ONE_VAL, ONE_VAL));
        matrix_queue.push_back('0);
        matrix_queue.push_back({NEL*EW{1'b1}});
        matrix_queue.push_back(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        matrix_queue.push_back(diag(32'h80000000, 32'h80000000, 32'h80000000));
        matrix_queue.push_back(diag(32'h80000000, 32'h7fffffff, 32'h80000000));
        matrix_queue.push_back(diag(32'd1, ONE_VAL, ONE_VAL));
        matrix_queue.push_back(diag(32'd2, ONE_VAL, ONE_VAL));
        matrix_queue.push_back(diag(32'hffffffff, ONE_VAL, 32'hffff0000));
        matrix_queue.push_back(diag(32'd3, 32'd3, 32'd3));
        m = '0;
        for (int k = 0; k < NEL; k++) m[k*EW +: EW] = (k % 2) ? 32'h80000000 : 32'h7fffffff;
        matrix_queue.push_back(m);
        for (int k = 0; k < NEL; k++) m[k*EW +: EW] = EW'((k + 1) * 40000 - (k % 3) * 99999);
        matrix_queue.push_back(m);
        wait_idle();

        // Limit boundary: |det| equal to the limit is singular, one above is not.
        write_limit(LW'(70000));
        matrix_queue.push_back(diag(32'd70000, ONE_VAL, ONE_VAL));
        matrix_queue.push_back(diag(32'd70001, ONE_VAL, ONE_VAL));
        matrix_queue.push_back(diag(-32'd70000, ONE_VAL, ONE_VAL));
        matrix_queue.push_back(diag(-32'd70001, ONE_VAL, ONE_VAL));
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_limit(p < 5 ? limits[p] : LW'($urandom()));
            for (int n = 0; n < 70; n++) matrix_queue.push_back(random_matrix());
            wait_idle();
        end

        if (mismatches == 0 && inverse_queue.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
